FILE: rtl/core/assert_macros.svh
// shared assertion macros for the execute core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cx8_pkg.sv
`timescale 1ns / 1ps

package cx8_pkg;

    // return stack sizing
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam logic [LVL_W-1:0] STACK_FULL = LVL_W'(STACK_DEPTH);

    // register file and address widths
    localparam int ADDR_W  = 12;
    localparam int DATA_W  = 8;
    localparam int INSTR_W = 16;
    localparam int RIDX_W  = 4;

    localparam logic [ADDR_W-1:0]  START_ADDR_RST = 12'h200;
    localparam logic [RIDX_W-1:0]  FLAG_IDX       = 4'hF;
    localparam logic [RIDX_W-1:0]  V0_IDX         = 4'h0;
    localparam logic [INSTR_W-1:0] INSTR_CLS      = 16'h00E0;
    localparam logic [INSTR_W-1:0] INSTR_RET      = 16'h00EE;

    // top nibble of the instruction word
    typedef enum logic [3:0] {
        OP_SYS  = 4'h0,
        OP_JP   = 4'h1,
        OP_CALL = 4'h2,
        OP_LD   = 4'h6,
        OP_ADD  = 4'h7,
        OP_ALU  = 4'h8,
        OP_SNE  = 4'h9,
        OP_LDI  = 4'hA,
        OP_JPV0 = 4'hB,
        OP_RND  = 4'hC
    } opcode_t;

    // low nibble of the 8xy_ group
    typedef enum logic [3:0] {
        ALU_MOV  = 4'h0,
        ALU_OR   = 4'h1,
        ALU_AND  = 4'h2,
        ALU_XOR  = 4'h3,
        ALU_ADD  = 4'h4,
        ALU_SUB  = 4'h5,
        ALU_SHR  = 4'h6,
        ALU_SUBN = 4'h7,
        ALU_SHL  = 4'hE
    } alu_op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_STACK   = 2'd2
    } status_t;

    // register file write from the execute stage
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

    // one result item
    typedef struct packed {
        logic [ADDR_W-1:0] next_address;
        logic [ADDR_W-1:0] index_value;
        logic [DATA_W-1:0] flag_value;
        logic              clear_screen;
        status_t           status;
    } result_t;

endpackage

FILE: rtl/core/cx8_regfile.sv
`timescale 1ns / 1ps

module cx8_regfile (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [cx8_pkg::RIDX_W-1:0]   rd_addr_a,
    input  logic [cx8_pkg::RIDX_W-1:0]   rd_addr_b,
    input  cx8_pkg::rf_wr_t              wr,
    output logic [cx8_pkg::DATA_W-1:0]   rd_data_a,
    output logic [cx8_pkg::DATA_W-1:0]   rd_data_b
);
    import cx8_pkg::*;

    localparam int NUM_REGS = 2 ** RIDX_W;

    logic [DATA_W-1:0]   bank_reg [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [DATA_W-1:0]   rd_a_reg;
    logic [DATA_W-1:0]   rd_b_reg;

    // storage write, no reset on the data
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            bank_reg[wr.addr] <= wr.data;
        end
    end

    // entries read as zero until first written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // registered reads with bypass of the write in the same cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr.en && (wr.addr == rd_addr_a)) begin
                rd_a_reg <= wr.data;
            end else if (valid_reg[rd_addr_a]) begin
                rd_a_reg <= bank_reg[rd_addr_a];
            end else begin
                rd_a_reg <= '0;
            end
            if (wr.en && (wr.addr == rd_addr_b)) begin
                rd_b_reg <= wr.data;
            end else if (valid_reg[rd_addr_b]) begin
                rd_b_reg <= bank_reg[rd_addr_b];
            end else begin
                rd_b_reg <= '0;
            end
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: rtl/core/cx8_exec.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cx8_exec (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [cx8_pkg::ADDR_W-1:0]    cfg_wdata,
    input  logic                          exec_en,
    input  logic [cx8_pkg::INSTR_W-1:0]   instr,
    input  logic [cx8_pkg::DATA_W-1:0]    rnd,
    input  logic [cx8_pkg::DATA_W-1:0]    rd_x,
    input  logic [cx8_pkg::DATA_W-1:0]    rd_y,
    output cx8_pkg::rf_wr_t               rf_wr,
    output cx8_pkg::result_t              res
);
    import cx8_pkg::*;

    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0] vf_reg, vf_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [ADDR_W-1:0] stack_reg [STACK_DEPTH];

    opcode_t           opcode;
    alu_op_t           alu_op;
    logic [RIDX_W-1:0] x_idx;
    logic [RIDX_W-1:0] y_idx;
    logic [DATA_W-1:0] kk;
    logic [ADDR_W-1:0] nnn;
    logic [DATA_W-1:0] vx;
    logic [DATA_W-1:0] vy;
    logic [DATA_W:0]   sum_xy;
    logic [ADDR_W-1:0] pc_plus2;
    logic [ADDR_W-1:0] pc_plus4;
    logic [LVL_W-1:0]  level_m1;
    logic [ADDR_W-1:0] stack_top;
    logic              push_en;
    logic              res_we;
    logic [DATA_W-1:0] res_data;
    logic              flag_we;
    logic [DATA_W-1:0] flag_data;
    logic              clear;
    status_t           status;

    // instruction fields and operands, VF lives outside the register file
    assign opcode    = opcode_t'(instr[15:12]);
    assign alu_op    = alu_op_t'(instr[3:0]);
    assign x_idx     = instr[11:8];
    assign y_idx     = instr[7:4];
    assign kk        = instr[7:0];
    assign nnn       = instr[ADDR_W-1:0];
    assign vx        = (x_idx == FLAG_IDX) ? vf_reg : rd_x;
    assign vy        = (y_idx == FLAG_IDX) ? vf_reg : rd_y;
    assign sum_xy    = {1'b0, vx} + {1'b0, vy};
    assign pc_plus2  = pc_reg + ADDR_W'(2);
    assign pc_plus4  = pc_reg + ADDR_W'(4);
    assign level_m1  = level_reg - 1'b1;
    assign stack_top = stack_reg[level_m1[SP_W-1:0]];

    // decode and execute
    always_comb begin
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        level_next = level_reg;
        push_en    = 1'b0;
        res_we     = 1'b0;
        res_data   = '0;
        flag_we    = 1'b0;
        flag_data  = '0;
        clear      = 1'b0;
        status     = ST_OK;
        case (opcode)
            OP_SYS: begin
                if (instr == INSTR_CLS) begin
                    clear   = 1'b1;
                    pc_next = pc_plus2;
                end else if (instr == INSTR_RET) begin
                    if ((level_reg == '0) || (level_reg > STACK_FULL)) begin
                        status = ST_STACK;
                    end else begin
                        level_next = level_m1;
                        pc_next    = stack_top + ADDR_W'(2);
                    end
                end else begin
                    status = ST_UNKNOWN;
                end
            end
            OP_JP: begin
                pc_next = nnn;
            end
            OP_CALL: begin
                if (level_reg >= STACK_FULL) begin
                    status = ST_STACK;
                end else begin
                    push_en    = 1'b1;
                    level_next = level_reg + 1'b1;
                    pc_next    = nnn;
                end
            end
            OP_LD: begin
                res_we   = 1'b1;
                res_data = kk;
                pc_next  = pc_plus2;
            end
            OP_ADD: begin
                res_we   = 1'b1;
                res_data = vx + kk;
                pc_next  = pc_plus2;
            end
            OP_ALU: begin
                res_we  = 1'b1;
                pc_next = pc_plus2;
                case (alu_op)
                    ALU_MOV: res_data = vy;
                    ALU_OR:  res_data = vx | vy;
                    ALU_AND: res_data = vx & vy;
                    ALU_XOR: res_data = vx ^ vy;
                    ALU_ADD: begin
                        res_data  = sum_xy[DATA_W-1:0];
                        flag_we   = 1'b1;
                        flag_data = DATA_W'(sum_xy[DATA_W]);
                    end
                    ALU_SUB: begin
                        res_data  = vx - vy;
                        flag_we   = 1'b1;
                        flag_data = DATA_W'(vx >= vy);
                    end
                    ALU_SHR: begin
                        res_data  = {1'b0, vx[DATA_W-1:1]};
                        flag_we   = 1'b1;
                        flag_data = DATA_W'(vx[0]);
                    end
                    ALU_SUBN: begin
                        res_data  = vy - vx;
                        flag_we   = 1'b1;
                        flag_data = DATA_W'(vy >= vx);
                    end
                    ALU_SHL: begin
                        res_data  = {vx[DATA_W-2:0], 1'b0};
                        flag_we   = 1'b1;
                        flag_data = DATA_W'(vx[DATA_W-1]);
                    end
                    default: begin
                        res_we  = 1'b0;
                        pc_next = pc_reg;
                        status  = ST_UNKNOWN;
                    end
                endcase
            end
            OP_SNE: begin
                pc_next = (vx != vy) ? pc_plus4 : pc_plus2;
            end
            OP_LDI: begin
                idx_next = nnn;
                pc_next  = pc_plus2;
            end
            OP_JPV0: begin
                // the y read port carries V0 for this opcode
                pc_next = nnn + {{(ADDR_W - DATA_W){1'b0}}, rd_y};
            end
            OP_RND: begin
                res_we   = 1'b1;
                res_data = rnd & kk;
                pc_next  = pc_plus2;
            end
            default: begin
                status = ST_UNKNOWN;
            end
        endcase
    end

    // flag first, a result aimed at VF wins
    always_comb begin
        if (res_we && (x_idx == FLAG_IDX)) begin
            vf_next = res_data;
        end else if (flag_we) begin
            vf_next = flag_data;
        end else begin
            vf_next = vf_reg;
        end
    end

    assign rf_wr.en   = exec_en && res_we && (x_idx != FLAG_IDX);
    assign rf_wr.addr = x_idx;
    assign rf_wr.data = res_data;

    assign res.next_address = pc_next;
    assign res.index_value  = idx_next;
    assign res.flag_value   = vf_next;
    assign res.clear_screen = clear;
    assign res.status       = status;

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg    <= START_ADDR_RST;
            idx_reg   <= '0;
            vf_reg    <= '0;
            level_reg <= '0;
        end else begin
            if (cfg_wen) begin
                pc_reg <= cfg_wdata;
            end else if (exec_en) begin
                pc_reg <= pc_next;
            end
            if (exec_en) begin
                idx_reg   <= idx_next;
                vf_reg    <= vf_next;
                level_reg <= level_next;
            end
        end
    end

    // return stack push
    always_ff @(posedge aclk) begin
        if (exec_en && push_en) begin
            stack_reg[level_reg[SP_W-1:0]] <= pc_reg;
        end
    end

    `ASSERT_ALWAYS(a_level_bound, aclk, aresetn, level_reg <= STACK_FULL, "stack level past depth")
    `ASSERT_NEXT(a_stack_err_hold, aclk, aresetn, exec_en && (status == ST_STACK), $stable(level_reg), "stack error moved level")
    `ASSERT_NEXT(a_unknown_hold, aclk, aresetn, exec_en && !cfg_wen && (status == ST_UNKNOWN), $stable(pc_reg) && $stable(vf_reg), "unknown opcode changed state")

endmodule

FILE: rtl/core/chip8_instruction_execute.sv
`timescale 1ns / 1ps
// an input transfer passes the input stage, then the result stage, to the m_ side
// throughput: one instruction per cycle, sustained while m_tready is high
// the register file read is registered at the input transfer, execute and
// state update happen once the result stage can take the result, with write bypass
// reset (aresetn low, synchronous): PC to 0x200, I, VF and stack level to zero,
// V0..VE read as zero, both stages empty

module chip8_instruction_execute (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [11:0] cfg_wdata,      // start_address
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,        // instruction[15:0], random_byte[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata         // next_address[11:0], index_value[23:12],
                                        // flag_value[31:24], clear_screen[32],
                                        // status[34:33], zero[39:35]
);
    import cx8_pkg::*;

    logic                 in_vld_reg, in_vld_next;
    logic [INSTR_W-1:0]   instr_reg;
    logic [DATA_W-1:0]    rnd_reg;
    logic                 out_vld_reg, out_vld_next;
    result_t              out_reg;
    logic                 s_fire;
    logic                 exec_en;
    logic [RIDX_W-1:0]    rd_addr_a;
    logic [RIDX_W-1:0]    rd_addr_b;
    logic [DATA_W-1:0]    rd_x;
    logic [DATA_W-1:0]    rd_y;
    rf_wr_t               rf_wr;
    result_t              res;

    // handshake between input stage and result stage
    assign exec_en      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready     = !in_vld_reg || exec_en;
    assign s_fire       = s_tvalid && s_tready;
    assign in_vld_next  = s_fire ? 1'b1 : (exec_en ? 1'b0 : in_vld_reg);
    assign out_vld_next = exec_en ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

    // read addresses taken straight from the incoming transfer
    assign rd_addr_a = s_tdata[11:8];
    assign rd_addr_b = (opcode_t'(s_tdata[15:12]) == OP_JPV0) ? V0_IDX : s_tdata[7:4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // input and result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            instr_reg <= s_tdata[INSTR_W-1:0];
            rnd_reg   <= s_tdata[INSTR_W+DATA_W-1:INSTR_W];
        end
        if (exec_en) begin
            out_reg <= res;
        end
    end

    cx8_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_fire),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr        (rf_wr),
        .rd_data_a (rd_x),
        .rd_data_b (rd_y)
    );

    cx8_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .exec_en   (exec_en),
        .instr     (instr_reg),
        .rnd       (rnd_reg),
        .rd_x      (rd_x),
        .rd_y      (rd_y),
        .rf_wr     (rf_wr),
        .res       (res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, out_reg.status, out_reg.clear_screen, out_reg.flag_value,
                       out_reg.index_value, out_reg.next_address};

endmodule
